// ----- design/assert_macros.svh -----
// Assertion helpers for the design checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, held off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/hsd_pkg.sv -----
package hsd_pkg;

    localparam int CW_W             = 63;
    localparam int LEN_W            = 6;
    localparam int DATA_W           = 57;
    localparam int NPAR             = 6;
    localparam int MAX_CODE_BITS_DEF = 63;

    // masked word after length saturation
    typedef struct packed {
        logic [CW_W-1:0]  word;
        logic [LEN_W-1:0] len;
    } t_s1;

    // word plus parity check result
    typedef struct packed {
        logic [CW_W-1:0]  word;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] syn;
        logic             oor;
    } t_s2;

    typedef struct packed {
        logic [CW_W-1:0]   corrected;
        logic [DATA_W-1:0] data_bits;
        logic [LEN_W-1:0]  data_len;
        logic [LEN_W-1:0]  syndrome;
        logic              out_of_range;
    } t_result;

    // Bit i set when code position i+1 is covered by parity position 2**k.
    function automatic logic [CW_W-1:0] f_par_mask(input int k);
        logic [CW_W-1:0] m;
        m = '0;
        for (int i = 0; i < CW_W; i++) begin
            m[i] = (((i + 1) >> k) & 1) != 0;
        end
        return m;
    endfunction

    // Gather the bits at non-power-of-two positions, lowest position first.
    function automatic logic [DATA_W-1:0] f_compact(input logic [CW_W-1:0] w);
        logic [DATA_W-1:0] d;
        int                j;
        d = '0;
        j = 0;
        for (int p = 1; p <= CW_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                d[j] = w[p-1];
                j++;
            end
        end
        return d;
    endfunction

endpackage

// ----- design/hsd_mask.sv -----
module hsd_mask #(
    parameter int MAX_CODE_BITS = hsd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hsd_pkg::CW_W-1:0]    i_codeword,
    input  logic [hsd_pkg::LEN_W-1:0]   i_code_len,
    output logic                        o_valid,
    input  logic                        i_ready,
    output hsd_pkg::t_s1                o_stage
);
    import hsd_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

    logic             r_valid;
    t_s1              r_stage;
    t_s1              n_stage;
    logic [LEN_W-1:0] len_sat;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        len_sat = (i_code_len > MAX_LEN) ? MAX_LEN : i_code_len;
        n_stage.len = len_sat;
        // drop every bit above the valid length
        for (int i = 0; i < CW_W; i++) begin
            n_stage.word[i] = i_codeword[i] && (LEN_W'(i) < len_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ----- design/hsd_syndrome.sv -----
module hsd_syndrome (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hsd_pkg::t_s1  i_stage,
    output logic          o_valid,
    input  logic          i_ready,
    output hsd_pkg::t_s2  o_stage
);
    import hsd_pkg::*;

    logic r_valid;
    t_s2  r_stage;
    t_s2  n_stage;

    assign o_ready = !r_valid || i_ready;

    // Parity groups above the length see only zero bits, so they never fail.
    always_comb begin
        n_stage.word = i_stage.word;
        n_stage.len  = i_stage.len;
        for (int k = 0; k < NPAR; k++) begin
            n_stage.syn[k] = ^(i_stage.word & f_par_mask(k));
        end
        n_stage.oor = n_stage.syn > i_stage.len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

// ----- design/hsd_correct.sv -----
module hsd_correct (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hsd_pkg::t_s2      i_stage,
    output logic              o_valid,
    input  logic              i_ready,
    output hsd_pkg::t_result  o_result
);
    import hsd_pkg::*;

    logic             r_valid;
    t_result          r_result;
    t_result          n_result;
    logic [LEN_W-1:0] npow;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // flip the bit the syndrome points at, unless it lies past the length
        for (int i = 0; i < CW_W; i++) begin
            n_result.corrected[i] = i_stage.word[i] ^
                ((i_stage.syn == LEN_W'(i + 1)) && !i_stage.oor);
        end
        n_result.data_bits = f_compact(n_result.corrected);
        // parity positions that fit inside the length
        npow = '0;
        for (int k = 0; k < NPAR; k++) begin
            npow = npow + LEN_W'(i_stage.len >= LEN_W'(1 << k));
        end
        n_result.data_len     = i_stage.len - npow;
        n_result.syndrome     = i_stage.syn;
        n_result.out_of_range = i_stage.oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- design/hamming_sec_decoder.sv -----
// Hamming single-error-correcting decoder, even parity, positions from 1.
// Input stream s_axis: one word per codeword, code bits plus their length.
// Output stream m_axis: one word per input word, in the same order, with the
// corrected codeword, packed message bits, their count and the syndrome;
// tuser flags a syndrome that points past the codeword (nothing flipped).
// Three register stages: length mask, parity check, correction and packing.
// An accepted word is registered in each stage in turn; one word is taken
// per cycle while m_axis_tready does not hold the pipeline full.
// The last stage is the output register, so a stalled receiver holds its
// result while bubbles in earlier stages keep s_axis_tready high; a full
// pipeline under stall drops s_axis_tready and nothing is lost or repeated.
// Reset clears all stage valid bits; the stage data registers are not reset.
// MAX_CODE_BITS caps the length: longer lengths are treated as the cap.
module hamming_sec_decoder #(
    parameter int MAX_CODE_BITS = hsd_pkg::MAX_CODE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [62:0] codeword, [68:63] code_len, [71:69] zero
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [62:0] corrected, [119:63] data_bits, [125:120] data_len,
    // [131:126] syndrome, [135:132] zero
    output logic [135:0] m_axis_tdata,
    // [0] out_of_range
    output logic [0:0]   m_axis_tuser
);
    import hsd_pkg::*;

    logic    s1_valid;
    logic    s1_ready;
    t_s1     s1_stage;
    logic    s2_valid;
    logic    s2_ready;
    t_s2     s2_stage;
    t_result result;

    hsd_mask #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_mask (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_codeword (s_axis_tdata[62:0]),
        .i_code_len (s_axis_tdata[68:63]),
        .o_valid    (s1_valid),
        .i_ready    (s1_ready),
        .o_stage    (s1_stage)
    );

    hsd_syndrome u_syndrome (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_stage (s1_stage),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_stage (s2_stage)
    );

    hsd_correct u_correct (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .o_ready  (s2_ready),
        .i_stage  (s2_stage),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {4'b0000, result.syndrome, result.data_len,
                           result.data_bits, result.corrected};
    assign m_axis_tuser = result.out_of_range;

endmodule

// ----- design/hsd_checker.sv -----
`include "assert_macros.svh"

module hsd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // a stalled result word stays put
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed under stall")

    // an out-of-range flag needs a nonzero syndrome
    `ASSERT_CLK(a_oor_syn, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[131:126] != 6'd0, "out_of_range with zero syndrome")

    // first message bit is code position 3
    `ASSERT_CLK(a_first_data, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[63] == m_axis_tdata[2], "data_bits not taken from corrected word")

    `ASSERT_CLK(a_dlen, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[125:120] <= 6'd57, "data_len above 57")

    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind hamming_sec_decoder hsd_checker u_hsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/hsd_checker.sv -----
`timescale 1ns / 100ps

// Watches both streams of the decoder, predicts every result word from the
// accepted input word and compares them in order.
module tb_hsd_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    // [62:0] codeword, [68:63] code_len, [71:69] zero
    input  logic [71:0]  i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    // [62:0] corrected, [119:63] data_bits, [125:120] data_len,
    // [131:126] syndrome, [135:132] zero
    input  logic [135:0] i_out_data,
    // [0] out_of_range
    input  logic [0:0]   i_out_user,
    output int           o_fail_count,
    output int           o_checked,
    output int           o_pending
);
    import hsd_pkg::*;

    t_result decoded_q[$];
    int      fails   = 0;
    int      checked = 0;

    function automatic t_result hamming_decode(input logic [CW_W-1:0] cw,
                                               input logic [LEN_W-1:0] len_in);
        t_result         r;
        logic [CW_W-1:0] w;
        int              len;
        int              syn;
        int              dlen;
        int              pw;
        logic            par;
        len = int'(len_in);
        if (len > MAX_CODE_BITS_DEF)
            len = MAX_CODE_BITS_DEF;
        w = cw;
        // drop everything past the codeword length
        for (int p = len; p < CW_W; p++)
            w[p] = 1'b0;
        syn = 0;
        for (int k = 0; k < NPAR; k++) begin
            pw = 1 << k;
            if (pw <= len) begin
                par = 1'b0;
                for (int p = 1; p <= len; p++)
                    if ((p & pw) != 0)
                        par ^= w[p-1];
                if (par)
                    syn += pw;
            end
        end
        r.out_of_range = (syn > len);
        if (syn != 0 && !r.out_of_range)
            w[syn-1] = ~w[syn-1];
        r.data_bits = '0;
        dlen = 0;
        for (int p = 1; p <= len; p++) begin
            if ((p & (p - 1)) != 0) begin
                r.data_bits[dlen] = w[p-1];
                dlen++;
            end
        end
        r.corrected = w;
        r.data_len  = dlen[LEN_W-1:0];
        r.syndrome  = syn[LEN_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                decoded_q.push_back(hamming_decode(i_in_data[62:0], i_in_data[68:63]));
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result word with no decode pending");
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("corrected", 64'(want.corrected),
                                64'(i_out_data[62:0]));
                    check_field("data_bits", 64'(want.data_bits),
                                64'(i_out_data[119:63]));
                    check_field("data_len", 64'(want.data_len),
                                64'(i_out_data[125:120]));
                    check_field("syndrome", 64'(want.syndrome),
                                64'(i_out_data[131:126]));
                    check_field("out_of_range", 64'(want.out_of_range),
                                64'(i_out_user[0]));
                    checked++;
                end
            end
        end
        o_pending    <= decoded_q.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

// ----- test/tb_hamming_sec_decoder.sv -----
`timescale 1ns / 100ps

module tb_hamming_sec_decoder;

    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 12;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int fail_cnt;
    int checked_cnt;
    int pending_cnt;
    int sent_cnt   = 0;
    int stuck_cnt  = 0;
    int hold_left  = 0;
    bit hold_req   = 1'b0;
    bit hold_ack   = 1'b0;
    bit rx_calm    = 1'b0;
    bit tx_calm    = 1'b0;

    hamming_sec_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tb_hsd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_cnt),
        .o_checked    (checked_cnt),
        .o_pending    (pending_cnt)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random backpressure, a calm stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= rx_calm || ($urandom_range(0, 99) >= 12);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cnt <= 0;
        else
            stuck_cnt <= stuck_cnt + 1;
        if (stuck_cnt >= STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [62:0] len_mask(input int len);
        logic [62:0] m;
        m = '0;
        for (int p = 0; p < len; p++)
            m[p] = 1'b1;
        return m;
    endfunction

    // Build a clean codeword of the given length around the given message bits.
    function automatic logic [62:0] encode(input logic [62:0] raw, input int len);
        logic [62:0] w;
        logic        par;
        int          pw;
        w = raw & len_mask(len);
        for (int k = 0; k < 6; k++) begin
            pw = 1 << k;
            if (pw <= len) begin
                w[pw-1] = 1'b0;
                par = 1'b0;
                for (int p = 1; p <= len; p++)
                    if ((p & pw) != 0)
                        par ^= w[p-1];
                w[pw-1] = par;
            end
        end
        return w;
    endfunction

    function automatic logic [62:0] rand_word();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[62:0];
    endfunction

    function automatic logic [62:0] flip(input logic [62:0] w, input int pos);
        logic [62:0] f;
        f = w;
        f[pos-1] = ~f[pos-1];
        return f;
    endfunction

    task automatic send_word(input logic [62:0] cw, input int len);
        while (!tx_calm && $urandom_range(0, 99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, len[5:0], cw};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sent_cnt++;
    endtask

    task automatic send_random();
        logic [62:0] cw;
        int          len;
        int          kind;
        int          a;
        int          b;
        len  = $urandom_range(0, 63);
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            cw = rand_word();
        end else begin
            cw = encode(rand_word(), len);
            if (kind < 75 && len > 0) begin
                cw = flip(cw, $urandom_range(1, len));
            end else if (kind < 88 && len > 1) begin
                a = $urandom_range(1, len);
                b = $urandom_range(1, len - 1);
                if (b >= a)
                    b++;
                cw = flip(flip(cw, a), b);
            end
            // junk above the length must be ignored
            if ($urandom_range(0, 3) == 0)
                cw |= rand_word() & ~len_mask(len);
        end
        send_word(cw, len);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (checked_cnt != sent_cnt)
            @(posedge i_clk);
    endtask

    initial begin
        logic [62:0] cw;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero and tiny lengths, with set bits past the length
        send_word('1, 0);
        send_word('0, 0);
        send_word('1, 1);
        send_word(63'h2, 1);
        send_word('1, 2);
        send_word('1, 3);
        // full length extremes and alternating patterns
        send_word('0, 63);
        send_word('1, 63);
        send_word(63'h2AAA_AAAA_AAAA_AAAA, 63);
        send_word(63'h5555_5555_5555_5555, 63);
        send_word(encode('1, 63), 63);
        // single errors on parity and message positions
        cw = encode(rand_word(), 63);
        send_word(cw, 63);
        send_word(flip(cw, 1), 63);
        send_word(flip(cw, 32), 63);
        send_word(flip(cw, 63), 63);
        send_word(flip(cw, 3), 63);
        // double error
        send_word(flip(flip(cw, 5), 9), 63);
        // syndrome past the codeword length, then a clean word with junk above its length
        send_word(flip(flip(encode(rand_word(), 5), 2), 4), 5);
        send_word(flip(flip(encode(rand_word(), 40), 16), 32), 40);
        send_word(encode(rand_word(), 7) | (rand_word() & ~len_mask(7)), 7);

        // sender pause until every result is back
        wait_drained();

        repeat (200)
            send_random();

        // receiver holds off while the sender keeps pushing
        hold_req <= ~hold_req;
        repeat (40)
            send_random();

        tx_calm = 1'b1;
        rx_calm <= 1'b1;
        repeat (200)
            send_random();
        tx_calm = 1'b0;
        rx_calm <= 1'b0;

        wait_drained();

        repeat (290)
            send_random();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);

        if (fail_cnt == 0 && pending_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/hsd_pkg.sv
design/hsd_mask.sv
design/hsd_syndrome.sv
design/hsd_correct.sv
design/hamming_sec_decoder.sv
design/hsd_checker.sv
test/hsd_checker.sv
test/tb_hamming_sec_decoder.sv
